/* sv/sliding_window_min_max_filter_macros.svh */
// ----------------------------------------------------------------------------
// Sliding window min/max filter assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_FILTER_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_FILTER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SWMM_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("swmm: invariant violated");

// A consequence that must hold in the cycle after its antecedent.
`define SWMM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swmm: next-cycle property violated");

`endif

/* sv/swmm_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window min/max filter package
// Sizes and types shared by the filter and its channel interfaces.
// ----------------------------------------------------------------------------
package swmm_pkg;

   localparam int MAX_HALF  = 7;
   localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
   localparam int TREE_W    = 16;
   localparam int SAMPLE_W  = 8;
   localparam int HALF_W    = 3;
   localparam int COUNT_W   = 4;

   typedef logic [SAMPLE_W-1:0]          sample_type;
   typedef logic [HALF_W-1:0]            half_type;
   typedef logic [COUNT_W-1:0]           count_type;
   typedef sample_type [WIN_DEPTH-1:0]   window_type;

   localparam half_type   HALF_RESET = half_type'(2);
   localparam count_type  FILL_MAX   = count_type'(WIN_DEPTH);
   localparam count_type  JOB_MAX    = count_type'(MAX_HALF + 1);
   localparam sample_type SAMPLE_MIN = '0;
   localparam sample_type SAMPLE_MAX = '1;

endpackage

/* sv/swmm_req_if.sv */
// ----------------------------------------------------------------------------
// Sliding window min/max filter request channel
// Carries one sample and its end-of-line flag per transaction.
// ----------------------------------------------------------------------------
interface swmm_req_if;

   logic                 valid;
   logic                 ready;
   swmm_pkg::sample_type sample;
   logic                 line_end;

   modport source (output valid, output sample, output line_end, input ready);
   modport sink   (input valid, input sample, input line_end, output ready);

endinterface

/* sv/swmm_rsp_if.sv */
// ----------------------------------------------------------------------------
// Sliding window min/max filter response channel
// Carries the window maximum, minimum and last-position flag per transaction.
// ----------------------------------------------------------------------------
interface swmm_rsp_if;

   logic                 valid;
   logic                 ready;
   swmm_pkg::sample_type max_value;
   swmm_pkg::sample_type min_value;
   logic                 last_of_line;

   modport source (output valid, output max_value, output min_value,
                   output last_of_line, input ready);
   modport sink   (input valid, input max_value, input min_value,
                   input last_of_line, output ready);

endinterface

/* sv/sliding_window_min_max_filter.sv */
// ----------------------------------------------------------------------------
// Sliding window min/max filter
// Centred-window maximum and minimum over a line of 8-bit samples, with the
// window clipped at both ends of the line.
// ----------------------------------------------------------------------------
// Each request transaction shifts one sample into a 15-entry window register
// and is copied, with its result count, into a job register; a 16-input
// comparator tree over that job produces one response per cycle, unless the
// receiver stalls, into the output register. A sample that yields at most
// one response is taken every cycle unless stalled, via the job and output
// registers. A line_end sample yields up to h+1 responses, one per cycle
// unless stalled, from the single tree, and the next request waits for the
// last. Responses lag the input by h samples; h is sampled at each request.
`include "sliding_window_min_max_filter_macros.svh"

module sliding_window_min_max_filter (
   input  logic               clock,
   input  logic               reset,
   swmm_req_if.sink           req_channel,
   swmm_rsp_if.source         rsp_channel,
   input  logic               csr_write_enable,
   input  swmm_pkg::half_type csr_write_data
);

   swmm_pkg::half_type   half_ff, half_in;
   swmm_pkg::window_type window_ff, window_in;
   swmm_pkg::count_type  fill_ff, fill_in;
   swmm_pkg::window_type job_win_ff, job_win_in;
   swmm_pkg::count_type  job_fill_ff, job_fill_in;
   swmm_pkg::count_type  job_kmax_ff, job_kmax_in;
   swmm_pkg::count_type  job_left_ff, job_left_in;
   logic                 job_last_ff, job_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   swmm_pkg::sample_type rsp_max_ff, rsp_max_in;
   swmm_pkg::sample_type rsp_min_ff, rsp_min_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 rsp_load;
   logic                 job_step;
   logic                 accept;
   logic                 fill_grows;
   swmm_pkg::window_type shifted;
   swmm_pkg::count_type  fill_next;
   swmm_pkg::count_type  half_wide;
   logic                 lag;
   swmm_pkg::count_type  pending;
   swmm_pkg::count_type  result_count;
   swmm_pkg::count_type  kmax_first;
   swmm_pkg::count_type  fill_top;
   swmm_pkg::count_type  eff_kmax;

   swmm_pkg::sample_type max_l0 [swmm_pkg::TREE_W];
   swmm_pkg::sample_type min_l0 [swmm_pkg::TREE_W];
   swmm_pkg::sample_type max_l1 [swmm_pkg::TREE_W/2];
   swmm_pkg::sample_type min_l1 [swmm_pkg::TREE_W/2];
   swmm_pkg::sample_type max_l2 [swmm_pkg::TREE_W/4];
   swmm_pkg::sample_type min_l2 [swmm_pkg::TREE_W/4];
   swmm_pkg::sample_type max_l3 [swmm_pkg::TREE_W/8];
   swmm_pkg::sample_type min_l3 [swmm_pkg::TREE_W/8];
   swmm_pkg::sample_type tree_max;
   swmm_pkg::sample_type tree_min;

   assign rsp_load = !rsp_valid_ff || rsp_channel.ready;
   assign job_step = (job_left_ff != '0) && rsp_load;
   assign req_channel.ready = (job_left_ff == '0)
                            || ((job_left_ff == swmm_pkg::count_type'(1)) && rsp_load);
   assign accept = req_channel.valid && req_channel.ready;
   assign fill_grows = accept && !req_channel.line_end && (fill_ff != swmm_pkg::FILL_MAX);

   assign rsp_channel.valid        = rsp_valid_ff;
   assign rsp_channel.max_value    = rsp_max_ff;
   assign rsp_channel.min_value    = rsp_min_ff;
   assign rsp_channel.last_of_line = rsp_last_ff;

   // Window update and the response schedule for the incoming sample.
   always_comb begin
      shifted   = {window_ff[swmm_pkg::WIN_DEPTH-2:0], req_channel.sample};
      fill_next = (fill_ff == swmm_pkg::FILL_MAX) ? fill_ff
                                                  : fill_ff + swmm_pkg::count_type'(1);
      half_wide = {1'b0, half_ff};
      lag       = fill_next >= (half_wide + swmm_pkg::count_type'(1));
      pending   = lag ? half_wide : fill_next;
      result_count = swmm_pkg::count_type'(lag)
                   + (req_channel.line_end ? pending : '0);
      kmax_first = lag ? {half_ff, 1'b0}
                       : fill_next + half_wide - swmm_pkg::count_type'(1);
   end

   // Clipped comparator tree over the job window.
   always_comb begin
      fill_top = job_fill_ff - swmm_pkg::count_type'(1);
      eff_kmax = (job_kmax_ff < fill_top) ? job_kmax_ff : fill_top;
      for (int k = 0; k < swmm_pkg::TREE_W; k++) begin
         if ((k < swmm_pkg::WIN_DEPTH) && (swmm_pkg::count_type'(k) <= eff_kmax)) begin
            max_l0[k] = job_win_ff[k % swmm_pkg::WIN_DEPTH];
            min_l0[k] = job_win_ff[k % swmm_pkg::WIN_DEPTH];
         end else begin
            max_l0[k] = swmm_pkg::SAMPLE_MIN;
            min_l0[k] = swmm_pkg::SAMPLE_MAX;
         end
      end
      for (int k = 0; k < swmm_pkg::TREE_W/2; k++) begin
         max_l1[k] = (max_l0[2*k] > max_l0[2*k+1]) ? max_l0[2*k] : max_l0[2*k+1];
         min_l1[k] = (min_l0[2*k] < min_l0[2*k+1]) ? min_l0[2*k] : min_l0[2*k+1];
      end
      for (int k = 0; k < swmm_pkg::TREE_W/4; k++) begin
         max_l2[k] = (max_l1[2*k] > max_l1[2*k+1]) ? max_l1[2*k] : max_l1[2*k+1];
         min_l2[k] = (min_l1[2*k] < min_l1[2*k+1]) ? min_l1[2*k] : min_l1[2*k+1];
      end
      for (int k = 0; k < swmm_pkg::TREE_W/8; k++) begin
         max_l3[k] = (max_l2[2*k] > max_l2[2*k+1]) ? max_l2[2*k] : max_l2[2*k+1];
         min_l3[k] = (min_l2[2*k] < min_l2[2*k+1]) ? min_l2[2*k] : min_l2[2*k+1];
      end
      tree_max = (max_l3[0] > max_l3[1]) ? max_l3[0] : max_l3[1];
      tree_min = (min_l3[0] < min_l3[1]) ? min_l3[0] : min_l3[1];
   end

   always_comb begin
      half_in      = csr_write_enable ? csr_write_data : half_ff;
      window_in    = window_ff;
      fill_in      = fill_ff;
      job_win_in   = job_win_ff;
      job_fill_in  = job_fill_ff;
      job_kmax_in  = job_kmax_ff;
      job_left_in  = job_left_ff;
      job_last_in  = job_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_last_in  = rsp_last_ff;

      if (accept) begin
         window_in   = shifted;
         fill_in     = req_channel.line_end ? '0 : fill_next;
         job_win_in  = shifted;
         job_fill_in = fill_next;
         job_kmax_in = kmax_first;
         job_left_in = result_count;
         job_last_in = req_channel.line_end;
      end else if (job_step) begin
         job_left_in = job_left_ff - swmm_pkg::count_type'(1);
         job_kmax_in = job_kmax_ff - swmm_pkg::count_type'(1);
      end

      if (job_step) begin
         rsp_valid_in = 1'b1;
         rsp_max_in   = tree_max;
         rsp_min_in   = tree_min;
         rsp_last_in  = job_last_ff && (job_left_ff == swmm_pkg::count_type'(1));
      end else if (rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= swmm_pkg::HALF_RESET;
         fill_ff      <= '0;
         job_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         half_ff      <= half_in;
         fill_ff      <= fill_in;
         job_left_ff  <= job_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      job_win_ff  <= job_win_in;
      job_fill_ff <= job_fill_in;
      job_kmax_ff <= job_kmax_in;
      job_last_ff <= job_last_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_last_ff <= rsp_last_in;
   end

   `SWMM_ASSERT_ALWAYS(a_job_bound, job_left_ff <= swmm_pkg::JOB_MAX)
   `SWMM_ASSERT_NEXT(a_line_end_clears, accept && req_channel.line_end, fill_ff == '0)
   `SWMM_ASSERT_NEXT(a_fill_counts, fill_grows, fill_ff == $past(fill_ff) + 4'd1)

endmodule

/* bench/sliding_window_min_max_filter_tb.sv */
// ----------------------------------------------------------------------------
// Sliding window min/max filter testbench
// Sends lines of samples through the filter at several window radii, keeps
// its own copy of the window to predict the maximum, minimum and end-of-line
// flag of every response, and checks each response transaction in order.
// Both channels idle and stall at random, and one long receiver hold-off
// makes the filter fill up and stall its input.
// ----------------------------------------------------------------------------
module sliding_window_min_max_filter_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLDOFF_CYCLES = 60;

   localparam int STALL_NONE    = 0;
   localparam int STALL_PATTERN = 1;
   localparam int STALL_RANDOM  = 2;

   typedef struct packed {
      swmm_pkg::sample_type max_value;
      swmm_pkg::sample_type min_value;
      logic                 last_of_line;
   } extremes_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   swmm_pkg::half_type csr_write_data;

   swmm_req_if req_if ();
   swmm_rsp_if rsp_if ();

   sliding_window_min_max_filter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if.sink),
      .rsp_channel      (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Shadow of the filter state.
   swmm_pkg::sample_type held_samples [swmm_pkg::WIN_DEPTH];
   int unsigned          held_count;
   swmm_pkg::half_type   radius;

   extremes_type expected_extremes [$];

   int error_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_max = 0;
   int stall_mode = STALL_NONE;
   int holdoff_request = 0;
   swmm_pkg::sample_type last_sample = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sliding_window_min_max_filter_tb NOT OK");
         $finish;
      end
   end

   // Extremes over the newest kmax+1 samples, clipped to the samples held.
   function automatic extremes_type window_extremes(input int unsigned kmax);
      extremes_type result;
      int unsigned last_k;
      result = '0;
      last_k = kmax;
      if (last_k > held_count - 1) last_k = held_count - 1;
      if (last_k > swmm_pkg::WIN_DEPTH - 1) last_k = swmm_pkg::WIN_DEPTH - 1;
      result.max_value = held_samples[0];
      result.min_value = held_samples[0];
      for (int unsigned k = 1; k <= last_k; k++) begin
         if (held_samples[k] > result.max_value) result.max_value = held_samples[k];
         if (held_samples[k] < result.min_value) result.min_value = held_samples[k];
      end
      return result;
   endfunction

   task automatic predict_filter_step(input swmm_pkg::sample_type sample,
                                      input logic line_end);
      int unsigned half;
      int unsigned pending;
      extremes_type step_results [$];
      extremes_type result;
      half = radius;
      if (half > swmm_pkg::MAX_HALF) half = swmm_pkg::MAX_HALF;
      for (int i = swmm_pkg::WIN_DEPTH - 1; i > 0; i--) held_samples[i] = held_samples[i - 1];
      held_samples[0] = sample;
      if (held_count < swmm_pkg::WIN_DEPTH) held_count++;
      if (held_count >= half + 1) begin
         step_results.insert(step_results.size(), window_extremes(2 * half));
      end
      if (line_end) begin
         pending = (held_count >= half + 1) ? half : held_count;
         while (pending > 0) begin
            step_results.insert(step_results.size(), window_extremes(pending - 1 + half));
            pending--;
         end
         foreach (held_samples[i]) held_samples[i] = '0;
         held_count = 0;
      end
      foreach (step_results[k]) begin
         result = step_results[k];
         if (line_end && k == step_results.size() - 1) result.last_of_line = 1'b1;
         expected_extremes.insert(expected_extremes.size(), result);
      end
   endtask

   task automatic send_sample(input swmm_pkg::sample_type sample, input logic line_end);
      if (burst_left == 0) begin
         if (gap_max > 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_if.valid    <= 1'b1;
      req_if.sample   <= sample;
      req_if.line_end <= line_end;
      do @(posedge clock); while (!req_if.ready);
      predict_filter_step(sample, line_end);
      last_sample = sample;
   endtask

   task automatic wait_for_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (expected_extremes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_radius(input swmm_pkg::half_type half);
      csr_write_enable <= 1'b1;
      csr_write_data   <= half;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      radius = half;
   endtask

   function automatic swmm_pkg::sample_type random_sample();
      case ($urandom_range(0, 7))
         0: return swmm_pkg::SAMPLE_MIN;
         1: return swmm_pkg::SAMPLE_MAX;
         2: return last_sample;
         default: return swmm_pkg::sample_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Receiver: checks every response transaction and drives ready.
   always @(posedge clock) begin : receiver
      extremes_type want;
      static int holdoff_taken = 0;
      static int holdoff_left = 0;
      static logic [15:0] stall_pattern = 16'b1101_1011_0111_0110;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_extremes.size() == 0) begin
               $error("unexpected result: max_value %0d, min_value %0d, last_of_line %0b",
                      rsp_if.max_value, rsp_if.min_value, rsp_if.last_of_line);
               error_count++;
            end else begin
               want = expected_extremes[0];
               expected_extremes.delete(0);
               if (rsp_if.max_value !== want.max_value) begin
                  $error("max_value: expected %0d, actual %0d",
                         want.max_value, rsp_if.max_value);
                  error_count++;
               end
               if (rsp_if.min_value !== want.min_value) begin
                  $error("min_value: expected %0d, actual %0d",
                         want.min_value, rsp_if.min_value);
                  error_count++;
               end
               if (rsp_if.last_of_line !== want.last_of_line) begin
                  $error("last_of_line: expected %0b, actual %0b",
                         want.last_of_line, rsp_if.last_of_line);
                  error_count++;
               end
            end
         end
         if (holdoff_request != holdoff_taken) begin
            holdoff_taken = holdoff_request;
            holdoff_left = HOLDOFF_CYCLES;
         end
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (stall_mode)
               STALL_PATTERN: rsp_if.ready <= stall_pattern[0];
               STALL_RANDOM:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
               default:       rsp_if.ready <= 1'b1;
            endcase
         end
      end
   end

   task automatic test_extreme_samples();
      send_sample(swmm_pkg::SAMPLE_MAX, 1'b0);
      send_sample(swmm_pkg::SAMPLE_MIN, 1'b0);
      send_sample(swmm_pkg::SAMPLE_MAX, 1'b0);
      send_sample(swmm_pkg::SAMPLE_MIN, 1'b0);
      send_sample(swmm_pkg::sample_type'(128), 1'b1);
      wait_for_idle();
   endtask

   task automatic test_short_lines();
      write_radius(swmm_pkg::half_type'(swmm_pkg::MAX_HALF));
      send_sample(swmm_pkg::sample_type'(8'h5A), 1'b1);
      send_sample(swmm_pkg::SAMPLE_MIN, 1'b0);
      send_sample(swmm_pkg::SAMPLE_MAX, 1'b0);
      send_sample(swmm_pkg::sample_type'(17), 1'b1);
      wait_for_idle();
   endtask

   task automatic test_radius_zero();
      write_radius(swmm_pkg::half_type'(0));
      send_sample(swmm_pkg::sample_type'(200), 1'b0);
      send_sample(swmm_pkg::sample_type'(3), 1'b0);
      send_sample(swmm_pkg::SAMPLE_MAX, 1'b1);
      wait_for_idle();
   endtask

   task automatic test_widest_window();
      write_radius(swmm_pkg::half_type'(swmm_pkg::MAX_HALF));
      for (int i = 0; i < 9; i++) send_sample(swmm_pkg::sample_type'(i * 29 + 7), i == 8);
      wait_for_idle();
   endtask

   task automatic test_radius_change_mid_line();
      write_radius(swmm_pkg::half_type'(4));
      for (int i = 0; i < 6; i++) send_sample(random_sample(), 1'b0);
      wait_for_idle();
      write_radius(swmm_pkg::half_type'(1));
      send_sample(random_sample(), 1'b0);
      send_sample(random_sample(), 1'b1);
      wait_for_idle();
   endtask

   task automatic test_output_backpressure();
      write_radius(swmm_pkg::half_type'(3));
      stall_mode = STALL_NONE;
      gap_max = 0;
      holdoff_request++;
      for (int i = 0; i < 30; i++) send_sample(random_sample(), i == 29);
      wait_for_idle();
   endtask

   task automatic test_random_lines();
      int sent;
      int line_length;
      for (int phase = 0; phase < 7; phase++) begin
         if (phase == 0) write_radius(swmm_pkg::half_type'(swmm_pkg::MAX_HALF));
         else if (phase == 1) write_radius(swmm_pkg::half_type'(0));
         else write_radius(swmm_pkg::half_type'($urandom_range(0, swmm_pkg::MAX_HALF)));
         stall_mode = (phase == 2) ? STALL_NONE : $urandom_range(STALL_NONE, STALL_RANDOM);
         gap_max = (phase == 2) ? 0 : $urandom_range(0, 6);
         sent = 0;
         while (sent < 15) begin
            if ($urandom_range(0, 5) == 0) line_length = $urandom_range(1, 3);
            else line_length = $urandom_range(4, 18);
            for (int i = 0; i < line_length; i++) begin
               send_sample(random_sample(), i == line_length - 1);
               sent++;
            end
         end
         wait_for_idle();
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.sample    = '0;
      req_if.line_end  = 1'b0;
      rsp_if.ready     = 1'b0;
      foreach (held_samples[i]) held_samples[i] = '0;
      held_count = 0;
      radius = swmm_pkg::HALF_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      stall_mode = STALL_PATTERN;
      gap_max = 3;
      test_extreme_samples();
      test_short_lines();
      test_radius_zero();
      test_widest_window();
      test_radius_change_mid_line();
      test_output_backpressure();
      test_random_lines();

      wait_for_idle();
      if (error_count == 0) begin
         $display("sliding_window_min_max_filter_tb OK");
      end else begin
         $display("sliding_window_min_max_filter_tb NOT OK");
      end
      $finish;
   end

endmodule
